// ===== src/pidc_pkg.sv =====
// Shared constants, types and microcode word layout for the PID controller
package pidc_pkg;

   localparam int FX_W      = 32;
   localparam int TIME_W    = 31;
   localparam int ERR_W     = 33;
   localparam int DIFF_W    = 34;
   localparam int WIDE_W    = 48;
   localparam int NARROW_W  = 33;
   localparam int MAG_N_W   = 32;
   localparam int SEG_W     = 24;
   localparam int PP_W      = SEG_W + MAG_N_W;
   localparam int ACC_W     = WIDE_W + MAG_N_W;
   localparam int FRAC_W    = 16;
   localparam int SUM_W     = 50;
   localparam int CSR_IDX_W = 3;
   localparam int PC_W      = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_INV   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MAX    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_MIN    = 3'd6;

   localparam logic [TIME_W-1:0] STEP_TIME_RST = 31'd65536;
   localparam logic [TIME_W-1:0] STEP_INV_RST  = 31'd65536;
   localparam logic [FX_W-1:0]   OUT_MAX_RST   = 32'h7FFF_FFFF;
   localparam logic [FX_W-1:0]   OUT_MIN_RST   = 32'h8000_0000;

   localparam logic [WIDE_W-1:0] WIDE_POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [WIDE_W-1:0] WIDE_NEG_MIN = 48'h8000_0000_0000;

   typedef enum logic [2:0] {
      OP_LOAD, OP_MSET, OP_MLO, OP_MHI, OP_MFIN, OP_INTEG, OP_EMIT
   } op_type;

   typedef enum logic [1:0] {W_ERR, W_DIFF, W_T, W_ESUM} wsel_type;

   typedef enum logic [2:0] {N_KP, N_KI, N_KD, N_DT, N_IDT} nsel_type;

   typedef enum logic [1:0] {D_SUMCLR, D_SUMADD, D_T} dst_type;

   typedef enum logic [1:0] {J_NEXT, J_HOLD_REQ, J_HOLD_RSP} jc_type;

   typedef struct packed {
      op_type              op;
      wsel_type            wsel;
      nsel_type            nsel;
      dst_type             dst;
      jc_type              jc;
      logic [PC_W-1:0]     target;
   } ucode_type;

   typedef struct packed {
      logic mset;
      logic mlo;
      logic mhi;
   } mul_ctl_type;

endpackage

// ===== src/pidc_if.sv =====
// Valid/ready channel interfaces for request and response words
interface pidc_req_if;
   logic                               valid;
   logic                               ready;
   logic signed [pidc_pkg::FX_W-1:0]   set_point;
   logic signed [pidc_pkg::FX_W-1:0]   measured_value;

   modport source (output valid, output set_point, output measured_value, input ready);
   modport sink   (input valid, input set_point, input measured_value, output ready);
endinterface

interface pidc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [pidc_pkg::FX_W-1:0]   drive;
   logic                               limited;

   modport source (output valid, output drive, output limited, input ready);
   modport sink   (input valid, input drive, input limited, output ready);
endinterface

// ===== src/pidc_mul.sv =====
// Shared sign-magnitude multiplier: two 24x32 passes, round, saturate to 48 bits
module pidc_mul (
   input  logic                                   clock,
   input  pidc_pkg::mul_ctl_type                  ctl,
   input  logic [pidc_pkg::WIDE_W-1:0]            wide_opnd,
   input  logic [pidc_pkg::NARROW_W-1:0]          narrow_opnd,
   output logic [pidc_pkg::WIDE_W-1:0]            result
);

   localparam logic [pidc_pkg::ACC_W-1:0] ROUND_HALF =
      pidc_pkg::ACC_W'(1) << (pidc_pkg::FRAC_W - 1);
   localparam logic [pidc_pkg::ACC_W-pidc_pkg::FRAC_W-1:0] CAP_POS =
      (pidc_pkg::ACC_W-pidc_pkg::FRAC_W)'(pidc_pkg::WIDE_POS_MAX);
   localparam logic [pidc_pkg::ACC_W-pidc_pkg::FRAC_W-1:0] CAP_NEG =
      (pidc_pkg::ACC_W-pidc_pkg::FRAC_W)'(pidc_pkg::WIDE_NEG_MIN);

   logic [pidc_pkg::WIDE_W-1:0]                 mag_w_ff, mag_w_in;
   logic [pidc_pkg::MAG_N_W-1:0]                mag_n_ff, mag_n_in;
   logic                                        neg_ff, neg_in;
   logic [pidc_pkg::ACC_W-1:0]                  acc_ff, acc_in;
   logic [pidc_pkg::NARROW_W-1:0]               narrow_mag;
   logic [pidc_pkg::SEG_W-1:0]                  seg;
   logic [pidc_pkg::PP_W-1:0]                   pp;
   logic [pidc_pkg::ACC_W-pidc_pkg::FRAC_W-1:0] quo, cap;
   logic [pidc_pkg::WIDE_W-1:0]                 r_mag;

   always_comb begin
      mag_w_in   = mag_w_ff;
      mag_n_in   = mag_n_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      narrow_mag = narrow_opnd[pidc_pkg::NARROW_W-1] ? (~narrow_opnd + 1'b1) : narrow_opnd;
      seg        = ctl.mlo ? mag_w_ff[pidc_pkg::SEG_W-1:0]
                           : mag_w_ff[pidc_pkg::WIDE_W-1:pidc_pkg::SEG_W];
      pp         = {{pidc_pkg::MAG_N_W{1'b0}}, seg} * {{pidc_pkg::SEG_W{1'b0}}, mag_n_ff};
      if (ctl.mset) begin
         mag_w_in = wide_opnd[pidc_pkg::WIDE_W-1] ? (~wide_opnd + 1'b1) : wide_opnd;
         mag_n_in = narrow_mag[pidc_pkg::MAG_N_W-1:0];
         neg_in   = wide_opnd[pidc_pkg::WIDE_W-1] ^ narrow_opnd[pidc_pkg::NARROW_W-1];
      end
      if (ctl.mlo) begin
         acc_in = {{(pidc_pkg::ACC_W-pidc_pkg::PP_W){1'b0}}, pp} + ROUND_HALF;
      end else if (ctl.mhi) begin
         acc_in = acc_ff + {pp, {pidc_pkg::SEG_W{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      mag_w_ff <= mag_w_in;
      mag_n_ff <= mag_n_in;
      neg_ff   <= neg_in;
      acc_ff   <= acc_in;
   end

   // round already added; drop fraction, clamp magnitude, restore sign
   always_comb begin
      quo    = acc_ff[pidc_pkg::ACC_W-1:pidc_pkg::FRAC_W];
      cap    = neg_ff ? CAP_NEG : CAP_POS;
      r_mag  = (quo > cap) ? cap[pidc_pkg::WIDE_W-1:0] : quo[pidc_pkg::WIDE_W-1:0];
      result = neg_ff ? (~r_mag + 1'b1) : r_mag;
   end

endmodule

// ===== src/pidc_seq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps
module pidc_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   rsp_busy,
   output pidc_pkg::ucode_type    uc
);

   localparam logic [pidc_pkg::PC_W-1:0] FETCH_PC = '0;

   logic [pidc_pkg::PC_W-1:0] pc_ff, pc_in;

   function automatic pidc_pkg::ucode_type mk(
      input pidc_pkg::op_type       op,
      input pidc_pkg::wsel_type     wsel,
      input pidc_pkg::nsel_type     nsel,
      input pidc_pkg::dst_type      dst,
      input pidc_pkg::jc_type       jc
   );
      pidc_pkg::ucode_type w;
      w.op     = op;
      w.wsel   = wsel;
      w.nsel   = nsel;
      w.dst    = dst;
      w.jc     = jc;
      w.target = FETCH_PC;
      return w;
   endfunction

   function automatic pidc_pkg::ucode_type ucode_rom(input logic [pidc_pkg::PC_W-1:0] pc);
      pidc_pkg::ucode_type w;
      case (pc)
         5'd0:  w = mk(pidc_pkg::OP_LOAD,  pidc_pkg::W_ERR,  pidc_pkg::N_KP,  pidc_pkg::D_T,      pidc_pkg::J_HOLD_REQ);
         // proportional
         5'd1:  w = mk(pidc_pkg::OP_MSET, pidc_pkg::W_ERR,  pidc_pkg::N_KP,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd2:  w = mk(pidc_pkg::OP_MLO,  pidc_pkg::W_ERR,  pidc_pkg::N_KP,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd3:  w = mk(pidc_pkg::OP_MHI,  pidc_pkg::W_ERR,  pidc_pkg::N_KP,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd4:  w = mk(pidc_pkg::OP_MFIN, pidc_pkg::W_ERR,  pidc_pkg::N_KP,  pidc_pkg::D_SUMCLR, pidc_pkg::J_NEXT);
         // error change times inverse step
         5'd5:  w = mk(pidc_pkg::OP_MSET, pidc_pkg::W_DIFF, pidc_pkg::N_IDT, pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd6:  w = mk(pidc_pkg::OP_MLO,  pidc_pkg::W_DIFF, pidc_pkg::N_IDT, pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd7:  w = mk(pidc_pkg::OP_MHI,  pidc_pkg::W_DIFF, pidc_pkg::N_IDT, pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd8:  w = mk(pidc_pkg::OP_MFIN, pidc_pkg::W_DIFF, pidc_pkg::N_IDT, pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         // derivative
         5'd9:  w = mk(pidc_pkg::OP_MSET, pidc_pkg::W_T,    pidc_pkg::N_KD,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd10: w = mk(pidc_pkg::OP_MLO,  pidc_pkg::W_T,    pidc_pkg::N_KD,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd11: w = mk(pidc_pkg::OP_MHI,  pidc_pkg::W_T,    pidc_pkg::N_KD,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd12: w = mk(pidc_pkg::OP_MFIN, pidc_pkg::W_T,    pidc_pkg::N_KD,  pidc_pkg::D_SUMADD, pidc_pkg::J_NEXT);
         // error times step, into accumulator
         5'd13: w = mk(pidc_pkg::OP_MSET, pidc_pkg::W_ERR,  pidc_pkg::N_DT,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd14: w = mk(pidc_pkg::OP_MLO,  pidc_pkg::W_ERR,  pidc_pkg::N_DT,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd15: w = mk(pidc_pkg::OP_MHI,  pidc_pkg::W_ERR,  pidc_pkg::N_DT,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd16: w = mk(pidc_pkg::OP_MFIN, pidc_pkg::W_ERR,  pidc_pkg::N_DT,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd17: w = mk(pidc_pkg::OP_INTEG, pidc_pkg::W_ESUM, pidc_pkg::N_KI, pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         // integral
         5'd18: w = mk(pidc_pkg::OP_MSET, pidc_pkg::W_ESUM, pidc_pkg::N_KI,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd19: w = mk(pidc_pkg::OP_MLO,  pidc_pkg::W_ESUM, pidc_pkg::N_KI,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd20: w = mk(pidc_pkg::OP_MHI,  pidc_pkg::W_ESUM, pidc_pkg::N_KI,  pidc_pkg::D_T,      pidc_pkg::J_NEXT);
         5'd21: w = mk(pidc_pkg::OP_MFIN, pidc_pkg::W_ESUM, pidc_pkg::N_KI,  pidc_pkg::D_SUMADD, pidc_pkg::J_NEXT);
         5'd22: w = mk(pidc_pkg::OP_EMIT, pidc_pkg::W_ERR,  pidc_pkg::N_KP,  pidc_pkg::D_T,      pidc_pkg::J_HOLD_RSP);
         default: w = mk(pidc_pkg::OP_LOAD, pidc_pkg::W_ERR, pidc_pkg::N_KP, pidc_pkg::D_T,      pidc_pkg::J_HOLD_REQ);
      endcase
      return w;
   endfunction

   assign uc = ucode_rom(pc_ff);

   always_comb begin
      pc_in = pc_ff + 1'b1;
      unique case (uc.jc)
         pidc_pkg::J_HOLD_REQ: begin
            if (!req_valid) pc_in = pc_ff;
         end
         pidc_pkg::J_HOLD_RSP: begin
            pc_in = rsp_busy ? pc_ff : uc.target;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= FETCH_PC;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== src/pid_controller_clamped_unit.sv =====
// PID controller top level: registers, datapath, sequencer and shared multiplier
// Five products pass through the one 24x32 multiplier, four microcode steps each;
//   a new request is only taken once the previous one has been emitted, and the
//   emit step stalls while the response register is still full.
// A new request is taken while the previous response still waits in its register.
// Reset (synchronous): registers to defaults, integral and previous error to zero,
//   response register empty, sequencer at its fetch step.
module pid_controller_clamped_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   pidc_req_if.sink                             req_chan,
   pidc_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidc_pkg::FX_W-1:0]            csr_wdata
);

   pidc_pkg::ucode_type                 uc;
   pidc_pkg::mul_ctl_type               mul_ctl;

   logic [pidc_pkg::FX_W-1:0]           kp_ff, ki_ff, kd_ff, out_max_ff, out_min_ff;
   logic [pidc_pkg::TIME_W-1:0]         dt_ff, idt_ff;

   logic [pidc_pkg::ERR_W-1:0]          err_ff, err_in, last_err_ff, last_err_in;
   logic [pidc_pkg::DIFF_W-1:0]         diff_ff, diff_in;
   logic [pidc_pkg::WIDE_W-1:0]         t_ff, t_in, esum_ff, esum_in;
   logic [pidc_pkg::SUM_W-1:0]          sum_ff, sum_in;
   logic [pidc_pkg::FX_W-1:0]           drive_ff, drive_in;
   logic                                limited_ff, limited_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   logic [pidc_pkg::WIDE_W-1:0]         wide_opnd, mul_res;
   logic [pidc_pkg::NARROW_W-1:0]       narrow_opnd;
   logic [pidc_pkg::WIDE_W:0]           integ_sum;
   logic [pidc_pkg::SUM_W-1:0]          hi_lim, lo_lim;
   logic                                rsp_busy, load, emit;

   assign rsp_busy = rsp_valid_ff && !rsp_chan.ready;
   assign load     = (uc.op == pidc_pkg::OP_LOAD) && req_chan.valid;
   assign emit     = (uc.op == pidc_pkg::OP_EMIT) && !rsp_busy;

   assign req_chan.ready   = (uc.op == pidc_pkg::OP_LOAD);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.drive   = drive_ff;
   assign rsp_chan.limited = limited_ff;

   assign mul_ctl.mset = (uc.op == pidc_pkg::OP_MSET);
   assign mul_ctl.mlo  = (uc.op == pidc_pkg::OP_MLO);
   assign mul_ctl.mhi  = (uc.op == pidc_pkg::OP_MHI);

   pidc_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_busy  (rsp_busy),
      .uc        (uc)
   );

   pidc_mul u_mul (
      .clock       (clock),
      .ctl         (mul_ctl),
      .wide_opnd   (wide_opnd),
      .narrow_opnd (narrow_opnd),
      .result      (mul_res)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff      <= '0;
         ki_ff      <= '0;
         kd_ff      <= '0;
         dt_ff      <= pidc_pkg::STEP_TIME_RST;
         idt_ff     <= pidc_pkg::STEP_INV_RST;
         out_max_ff <= pidc_pkg::OUT_MAX_RST;
         out_min_ff <= pidc_pkg::OUT_MIN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            pidc_pkg::CSR_PROP_GAIN:  kp_ff      <= csr_wdata;
            pidc_pkg::CSR_INTEG_GAIN: ki_ff      <= csr_wdata;
            pidc_pkg::CSR_DERIV_GAIN: kd_ff      <= csr_wdata;
            pidc_pkg::CSR_STEP_TIME:  dt_ff      <= csr_wdata[pidc_pkg::TIME_W-1:0];
            pidc_pkg::CSR_STEP_INV:   idt_ff     <= csr_wdata[pidc_pkg::TIME_W-1:0];
            pidc_pkg::CSR_OUT_MAX:    out_max_ff <= csr_wdata;
            pidc_pkg::CSR_OUT_MIN:    out_min_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // operand selection
   always_comb begin
      unique case (uc.wsel)
         pidc_pkg::W_ERR:  wide_opnd = {{(pidc_pkg::WIDE_W-pidc_pkg::ERR_W){err_ff[pidc_pkg::ERR_W-1]}},
                                        err_ff};
         pidc_pkg::W_DIFF: wide_opnd = {{(pidc_pkg::WIDE_W-pidc_pkg::DIFF_W){diff_ff[pidc_pkg::DIFF_W-1]}},
                                        diff_ff};
         pidc_pkg::W_T:    wide_opnd = t_ff;
         default:          wide_opnd = esum_ff;
      endcase
      unique case (uc.nsel)
         pidc_pkg::N_KP:  narrow_opnd = {kp_ff[pidc_pkg::FX_W-1], kp_ff};
         pidc_pkg::N_KI:  narrow_opnd = {ki_ff[pidc_pkg::FX_W-1], ki_ff};
         pidc_pkg::N_KD:  narrow_opnd = {kd_ff[pidc_pkg::FX_W-1], kd_ff};
         pidc_pkg::N_DT:  narrow_opnd = {2'b00, dt_ff};
         pidc_pkg::N_IDT: narrow_opnd = {2'b00, idt_ff};
         default:         narrow_opnd = '0;
      endcase
   end

   // datapath
   always_comb begin
      err_in       = err_ff;
      diff_in      = diff_ff;
      t_in         = t_ff;
      sum_in       = sum_ff;
      esum_in      = esum_ff;
      last_err_in  = last_err_ff;
      drive_in     = drive_ff;
      limited_in   = limited_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      integ_sum    = {esum_ff[pidc_pkg::WIDE_W-1], esum_ff} + {t_ff[pidc_pkg::WIDE_W-1], t_ff};
      hi_lim       = {{(pidc_pkg::SUM_W-pidc_pkg::FX_W){out_max_ff[pidc_pkg::FX_W-1]}}, out_max_ff};
      lo_lim       = {{(pidc_pkg::SUM_W-pidc_pkg::FX_W){out_min_ff[pidc_pkg::FX_W-1]}}, out_min_ff};

      if (load) begin
         err_in  = {req_chan.set_point[pidc_pkg::FX_W-1], req_chan.set_point}
                 - {req_chan.measured_value[pidc_pkg::FX_W-1], req_chan.measured_value};
         diff_in = {{2{req_chan.set_point[pidc_pkg::FX_W-1]}}, req_chan.set_point}
                 - {{2{req_chan.measured_value[pidc_pkg::FX_W-1]}}, req_chan.measured_value}
                 - {last_err_ff[pidc_pkg::ERR_W-1], last_err_ff};
      end

      if (uc.op == pidc_pkg::OP_MFIN) begin
         unique case (uc.dst)
            pidc_pkg::D_SUMCLR: sum_in = {{2{mul_res[pidc_pkg::WIDE_W-1]}}, mul_res};
            pidc_pkg::D_SUMADD: sum_in = sum_ff + {{2{mul_res[pidc_pkg::WIDE_W-1]}}, mul_res};
            default:            t_in   = mul_res;
         endcase
      end

      // accumulator saturates at the 48-bit limits
      if (uc.op == pidc_pkg::OP_INTEG) begin
         if (integ_sum[pidc_pkg::WIDE_W] != integ_sum[pidc_pkg::WIDE_W-1]) begin
            esum_in = integ_sum[pidc_pkg::WIDE_W] ? pidc_pkg::WIDE_NEG_MIN : pidc_pkg::WIDE_POS_MAX;
         end else begin
            esum_in = integ_sum[pidc_pkg::WIDE_W-1:0];
         end
      end

      // upper limit checked first
      if (emit) begin
         rsp_valid_in = 1'b1;
         last_err_in  = err_ff;
         if ($signed(sum_ff) > $signed(hi_lim)) begin
            drive_in   = out_max_ff;
            limited_in = 1'b1;
         end else if ($signed(sum_ff) < $signed(lo_lim)) begin
            drive_in   = out_min_ff;
            limited_in = 1'b1;
         end else begin
            drive_in   = sum_ff[pidc_pkg::FX_W-1:0];
            limited_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff  <= '0;
         esum_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_err_ff  <= last_err_in;
         esum_ff      <= esum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      err_ff     <= err_in;
      diff_ff    <= diff_in;
      t_ff       <= t_in;
      sum_ff     <= sum_in;
      drive_ff   <= drive_in;
      limited_ff <= limited_in;
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken twice in a row");

   a_ready_after_emit: assert property (@(posedge clock) disable iff (reset)
      emit |=> (req_chan.ready && rsp_chan.valid))
      else $error("sequencer did not return to fetch after emitting");

   a_word_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && !emit) |=> !rsp_chan.valid)
      else $error("response word repeated");

endmodule

// ===== dv/pid_controller_clamped_unit_tb.sv =====
// Self-checking bench for the clamped PID controller against a shadow model
module pid_controller_clamped_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [pidc_pkg::CSR_IDX_W-1:0] CSR_SPARE = 3'd7;
   localparam longint WIDE_HI = (longint'(1) <<< 47) - 1;
   localparam longint WIDE_LO = -(longint'(1) <<< 47);
   localparam int HOLD_LEN   = 400;
   localparam int DRAIN_WAIT = 40;
   localparam int SHOW_MAX   = 10;
   localparam int RAND_PHASES = 6;
   localparam int PHASE_WORDS = 250;

   typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [pidc_pkg::FX_W-1:0] set_point;
      logic [pidc_pkg::FX_W-1:0] measured_value;
   } sample_type;

   typedef struct packed {
      logic [pidc_pkg::FX_W-1:0] drive;
      logic                      limited;
   } drive_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [pidc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pidc_pkg::FX_W-1:0]      csr_wdata = '0;

   pidc_req_if req_chan();
   pidc_rsp_if rsp_chan();

   pid_controller_clamped_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and loop state
   logic signed [pidc_pkg::FX_W-1:0]   prop_gain_q  = '0;
   logic signed [pidc_pkg::FX_W-1:0]   integ_gain_q = '0;
   logic signed [pidc_pkg::FX_W-1:0]   deriv_gain_q = '0;
   logic [pidc_pkg::TIME_W-1:0]        step_q       = pidc_pkg::STEP_TIME_RST;
   logic [pidc_pkg::TIME_W-1:0]        step_inv_q   = pidc_pkg::STEP_INV_RST;
   logic signed [pidc_pkg::FX_W-1:0]   out_max_q    = pidc_pkg::OUT_MAX_RST;
   logic signed [pidc_pkg::FX_W-1:0]   out_min_q    = pidc_pkg::OUT_MIN_RST;
   logic signed [pidc_pkg::ERR_W-1:0]  prev_error   = '0;
   logic signed [pidc_pkg::WIDE_W-1:0] integ_sum    = '0;

   sample_type sample_backlog[$];
   drive_type  drive_due[$];

   int send_idle_pct  = 0;
   int stall_pct      = 0;
   bit hold_on        = 1'b0;
   int hold_count     = 0;
   bit req_taken      = 1'b0;
   int mismatch_count = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // round(a*b / 2^16) ties away from zero, saturated to 48 bits
   function automatic longint fx_mul(input longint a, input longint b);
      logic [127:0] prod;
      logic [127:0] cap;
      logic         neg;
      neg  = (a < 0) != (b < 0);
      prod = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b) + 128'h8000;
      prod = prod >> pidc_pkg::FRAC_W;
      cap  = neg ? 128'(-WIDE_LO) : 128'(WIDE_HI);
      if (prod > cap)
         prod = cap;
      return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
   endfunction

   function automatic drive_type pid_predict(input sample_type s);
      longint err, p_term, d_term, i_term, acc, total;
      drive_type r;
      err    = longint'($signed(s.set_point)) - longint'($signed(s.measured_value));
      p_term = fx_mul(longint'(prop_gain_q), err);
      d_term = fx_mul(longint'(deriv_gain_q),
                      fx_mul(err - longint'(prev_error), longint'(step_inv_q)));
      acc = longint'(integ_sum) + fx_mul(err, longint'(step_q));
      if (acc > WIDE_HI)
         acc = WIDE_HI;
      else if (acc < WIDE_LO)
         acc = WIDE_LO;
      integ_sum = acc[pidc_pkg::WIDE_W-1:0];
      i_term    = fx_mul(longint'(integ_gain_q), acc);
      total     = p_term + d_term + i_term;
      r.limited = 1'b1;
      // upper limit checked first, so it wins when the limits cross
      if (total > longint'(out_max_q)) begin
         r.drive = out_max_q;
      end else if (total < longint'(out_min_q)) begin
         r.drive = out_min_q;
      end else begin
         r.drive   = total[pidc_pkg::FX_W-1:0];
         r.limited = 1'b0;
      end
      prev_error = err[pidc_pkg::ERR_W-1:0];
      return r;
   endfunction

   task automatic report(input string msg);
      mismatch_count++;
      if (mismatch_count <= SHOW_MAX)
         $display("%0t: %s", $time, msg);
   endtask

   // monitor: register shadow, result check, prediction on accept
   always @(posedge clock) begin : monitor
      drive_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (csr_we) begin
            case (csr_index)
               pidc_pkg::CSR_PROP_GAIN:  prop_gain_q  = csr_wdata;
               pidc_pkg::CSR_INTEG_GAIN: integ_gain_q = csr_wdata;
               pidc_pkg::CSR_DERIV_GAIN: deriv_gain_q = csr_wdata;
               pidc_pkg::CSR_STEP_TIME:  step_q       = csr_wdata[pidc_pkg::TIME_W-1:0];
               pidc_pkg::CSR_STEP_INV:   step_inv_q   = csr_wdata[pidc_pkg::TIME_W-1:0];
               pidc_pkg::CSR_OUT_MAX:    out_max_q    = csr_wdata;
               pidc_pkg::CSR_OUT_MIN:    out_min_q    = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (drive_due.size() == 0) begin
               report($sformatf("unexpected word: drive %h limited %b",
                                rsp_chan.drive, rsp_chan.limited));
            end else begin
               want = drive_due.pop_front();
               if (rsp_chan.drive !== want.drive || rsp_chan.limited !== want.limited)
                  report($sformatf("drive exp %h got %h, limited exp %b got %b",
                                   want.drive, rsp_chan.drive,
                                   want.limited, rsp_chan.limited));
            end
         end
         if (req_chan.valid && req_chan.ready)
            drive_due.push_back(pid_predict({req_chan.set_point, req_chan.measured_value}));
      end
   end

   // driver: next word from the backlog once the current one is taken
   always @(negedge clock) begin : driver
      sample_type next_word;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_word = sample_backlog.pop_front();
            req_chan.valid          <= 1'b1;
            req_chan.set_point      <= next_word.set_point;
            req_chan.measured_value <= next_word.measured_value;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // response side: random stalls, plus one long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         hold_count     <= 0;
      end else if (hold_on && hold_count < HOLD_LEN) begin
         rsp_chan.ready <= 1'b0;
         hold_count     <= hold_count + 1;
      end else begin
         if (!hold_on)
            hold_count <= 0;
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic csr_write(input logic [pidc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [pidc_pkg::FX_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic load_settings(input logic [pidc_pkg::FX_W-1:0] kp, ki, kd, dt, idt, hi, lo);
      csr_write(pidc_pkg::CSR_PROP_GAIN, kp);
      csr_write(pidc_pkg::CSR_INTEG_GAIN, ki);
      csr_write(pidc_pkg::CSR_DERIV_GAIN, kd);
      csr_write(pidc_pkg::CSR_STEP_TIME, dt);
      csr_write(pidc_pkg::CSR_STEP_INV, idt);
      csr_write(pidc_pkg::CSR_OUT_MAX, hi);
      csr_write(pidc_pkg::CSR_OUT_MIN, lo);
      csr_write(CSR_SPARE, $urandom());
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      send_idle_pct = (mode == IDLE_SEND) ? 85 : (mode == IDLE_BOTH) ? 31 : 0;
      stall_pct     = (mode == IDLE_RECV) ? 85 : (mode == IDLE_BOTH) ? 31 : 0;
   endtask

   task automatic queue_sample(input logic [pidc_pkg::FX_W-1:0] sp,
                               input logic [pidc_pkg::FX_W-1:0] mv);
      sample_backlog.push_back({sp, mv});
   endtask

   task automatic drain();
      do
         @(posedge clock);
      while (sample_backlog.size() != 0 || req_chan.valid || drive_due.size() != 0);
   endtask

   function automatic logic [pidc_pkg::FX_W-1:0] pick_fx();
      case ($urandom_range(5))
         0, 1:    return $urandom();
         2, 3:    return pidc_pkg::FX_W'($urandom_range(2 ** 21) - 2 ** 20);
         4: begin
            case ($urandom_range(3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return '0;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         default: return $urandom() >> $urandom_range(31);
      endcase
   endfunction

   function automatic logic [pidc_pkg::FX_W-1:0] pick_gain();
      case ($urandom_range(3))
         0:    return $urandom();
         1, 2: return pidc_pkg::FX_W'($urandom_range(2 ** 19) - 2 ** 18);
         default: begin
            case ($urandom_range(4))
               0:       return '0;
               1:       return 32'h7FFF_FFFF;
               2:       return 32'h8000_0000;
               3:       return 32'h0001_0000;
               default: return 32'hFFFF_0000;
            endcase
         end
      endcase
   endfunction

   function automatic logic [pidc_pkg::FX_W-1:0] pick_step();
      case ($urandom_range(3))
         0:    return $urandom();
         1, 2: return $urandom_range(1, 2 ** 17);
         default: begin
            case ($urandom_range(3))
               0:       return '0;
               1:       return 32'd1;
               2:       return 32'h7FFF_FFFF;
               default: return 32'h0001_0000;
            endcase
         end
      endcase
   endfunction

   task automatic load_random_settings();
      logic [pidc_pkg::FX_W-1:0] hi, lo, a, b;
      a = pidc_pkg::FX_W'($urandom_range(2 ** 22));
      b = pidc_pkg::FX_W'($urandom_range(2 ** 22));
      case ($urandom_range(3))
         0: begin
            hi = $urandom();
            lo = $urandom();
         end
         1: begin
            hi = a;
            lo = -b;
         end
         2: begin
            hi = pidc_pkg::OUT_MAX_RST;
            lo = pidc_pkg::OUT_MIN_RST;
         end
         default: begin
            // crossed limits
            hi = -a;
            lo = b;
         end
      endcase
      load_settings(pick_gain(), pick_gain(), pick_gain(), pick_step(), pick_step(), hi, lo);
   endtask

   initial begin
      logic [pidc_pkg::FX_W-1:0] sp;
      req_chan.valid          = 1'b0;
      req_chan.set_point      = '0;
      req_chan.measured_value = '0;
      rsp_chan.ready          = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: all gains zero
      set_idling(IDLE_NONE);
      queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
      queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
      queue_sample('0, '0);
      drain();

      // half gain, zero step times, rounding ties and both limits
      load_settings(32'h0000_8000, '0, '0, '0, '0, 32'h0005_0000, 32'hFFFB_0000);
      queue_sample(32'h0003_0000, 32'h0001_0000);
      queue_sample(32'd1, '0);
      queue_sample('0, 32'd1);
      queue_sample(32'h000A_0000, '0);
      queue_sample('0, 32'h000A_0000);
      queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      // crossed limits: upper wins
      load_settings(32'h0001_0000, '0, '0, 32'h0001_0000, 32'h0001_0000,
                    32'hFFFF_0000, 32'h0001_0000);
      queue_sample(32'h0005_0000, '0);
      queue_sample(32'hFFFB_0000, '0);
      queue_sample('0, '0);
      drain();

      // extreme gains and steps: integrator and products saturate
      load_settings(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      repeat (4) queue_sample(32'h7FFF_FFFF, 32'h8000_0000);
      repeat (4) queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
      drain();

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         load_random_settings();
         set_idling(idle_mode_type'(ph % 4));
         hold_on = (ph == 4);
         repeat (PHASE_WORDS) begin
            sp = pick_fx();
            // about half tracking words with a small error, the rest unrelated
            if ($urandom_range(1))
               queue_sample(sp, sp - pidc_pkg::FX_W'($urandom_range(2 ** 17) - 2 ** 16));
            else
               queue_sample(sp, pick_fx());
         end
         drain();
         hold_on = 1'b0;
      end

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
